/* rtl/core/team_queue_defines.svh */
// Assertion macros shared by the team queue RTL.
`ifndef TEAM_QUEUE_DEFINES_SVH
`define TEAM_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define TQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Antecedent this cycle implies consequent next cycle.
`define TQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define TQ_ASSERT(lbl, prop, msg)
`define TQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/core/tq_pkg.sv */
// Sizes, codes and record types of the team queue.
package tq_pkg;

  // Sizing
  localparam int ELEMENT_IDS = 1024;
  localparam int TEAMS       = 64;
  localparam int TEAM_DEPTH  = 16;

  // Fixed item field widths
  localparam int FUNC_W   = 2;
  localparam int ELEM_W   = 10;
  localparam int TEAM_W   = 6;
  localparam int STATUS_W = 3;

  // Derived widths
  localparam int MEM_AW   = $clog2(ELEMENT_IDS);
  localparam int TEAM_AW  = $clog2(TEAMS);
  localparam int HEAD_W   = $clog2(TEAM_DEPTH);
  localparam int CNT_W    = $clog2(TEAM_DEPTH + 1);
  localparam int SLOTS    = TEAMS * TEAM_DEPTH;
  localparam int SLOT_AW  = $clog2(SLOTS);
  localparam int OCNT_W   = $clog2(TEAMS + 1);
  localparam int SWEEP_N  = (ELEMENT_IDS > TEAMS) ? ELEMENT_IDS : TEAMS;
  localparam int SWEEP_W  = $clog2(SWEEP_N);

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    F_ASSIGN  = 2'd0,
    F_ENQUEUE = 2'd1,
    F_DEQUEUE = 2'd2,
    F_CLEAR   = 2'd3
  } func_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_VALUE   = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  // Membership table entry
  typedef struct packed {
    logic               valid;
    logic [TEAM_AW-1:0] team;
  } memb_t;

  // Per-team FIFO bookkeeping
  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic [CNT_W-1:0]  count;
  } team_state_t;

endpackage

/* rtl/core/tq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tq_ram #(
  parameter int Depth = 16,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, read data registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/team_queue.sv */
// Team queue: top level with operation sequencer and state memories.
// Accept to result register runs a chain of dependent reads: assign goes straight to S_OUT;
// enqueue reads membership (S_RD1), then team state (S_RD2); dequeue reads the order ring
// (S_RD1), team state (S_RD2), then slot memory (S_RD3); unknown or empty items leave early.
// The next item is taken only once the result is registered, and not while it waits on m_axis_tready_i.
// Reset is asynchronous and active low; afterwards a sweep over max(ELEMENT_IDS, TEAMS)
// addresses clears membership and team state first; a clear item runs the same sweep.
`include "team_queue_defines.svh"

module team_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // func[1:0], element[11:2], team[17:12]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // status[2:0], value[12:3]
);
  import tq_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD1,
    S_RD2,
    S_RD3,
    S_OUT
  } state_e;

  localparam logic [SWEEP_W-1:0] SWEEP_LAST = SWEEP_W'(SWEEP_N - 1);

  state_e               state_q, state_d;
  func_e                func_q, func_d;
  logic [ELEM_W-1:0]    elem_q, elem_d;
  logic [TEAM_AW-1:0]   tm_q, tm_d;
  logic [SWEEP_W-1:0]   sweep_q, sweep_d;
  logic                 clr_res_q, clr_res_d;
  logic [TEAM_AW-1:0]   order_head_q, order_head_d;
  logic [TEAM_AW-1:0]   order_tail_q, order_tail_d;
  logic [OCNT_W-1:0]    order_count_q, order_count_d;
  status_e              res_status_q, res_status_d;
  logic [ELEM_W-1:0]    res_value_q, res_value_d;
  logic                 out_valid_q;
  status_e              out_status_q;
  logic [ELEM_W-1:0]    out_value_q;

  // Input item fields
  logic              acc;
  func_e             in_func;
  logic [ELEM_W-1:0] in_elem;
  logic [TEAM_W-1:0] in_team;

  // Memory ports
  logic               memb_we;
  logic [MEM_AW-1:0]  memb_waddr, memb_raddr;
  memb_t              memb_wdata, memb_rdata;
  logic               ts_we;
  logic [TEAM_AW-1:0] ts_waddr, ts_raddr;
  team_state_t        ts_wdata, ts_rdata;
  logic               slot_we;
  logic [SLOT_AW-1:0] slot_waddr, slot_raddr;
  logic [ELEM_W-1:0]  slot_rdata;
  logic               ring_we;
  logic [TEAM_AW-1:0] ring_rdata;

  // Derived values on the team state read
  logic [CNT_W:0]     pos_sum;
  logic [HEAD_W-1:0]  tail_pos, head_next;
  logic [SLOT_AW-1:0] slot_base;
  logic [TEAM_AW-1:0] otail_next, ohead_next;
  logic               out_free;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;
  assign in_func         = func_e'(s_axis_tdata_i[1:0]);
  assign in_elem         = s_axis_tdata_i[11:2];
  assign in_team         = s_axis_tdata_i[17:12];
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_value_q, out_status_q};

  // Slot position arithmetic for the team being worked on
  assign pos_sum    = (CNT_W + 1)'(ts_rdata.head) + (CNT_W + 1)'(ts_rdata.count);
  assign tail_pos   = (int'(pos_sum) >= TEAM_DEPTH) ?
                      HEAD_W'(pos_sum - (CNT_W + 1)'(TEAM_DEPTH)) : HEAD_W'(pos_sum);
  assign head_next  = (ts_rdata.head == HEAD_W'(TEAM_DEPTH - 1)) ? '0 : ts_rdata.head + 1'b1;
  assign slot_base  = SLOT_AW'(tm_q) * SLOT_AW'(TEAM_DEPTH);
  assign slot_waddr = slot_base + SLOT_AW'(tail_pos);
  assign slot_raddr = slot_base + SLOT_AW'(ts_rdata.head);
  assign otail_next = (order_tail_q == TEAM_AW'(TEAMS - 1)) ? '0 : order_tail_q + 1'b1;
  assign ohead_next = (order_head_q == TEAM_AW'(TEAMS - 1)) ? '0 : order_head_q + 1'b1;

  // Read addresses of membership and team state
  assign memb_raddr = MEM_AW'(in_elem);
  assign ts_raddr   = (state_q == S_RD1) ? tm_d : tm_q;

  // Sequencer
  always_comb begin
    state_d       = state_q;
    func_d        = func_q;
    elem_d        = elem_q;
    tm_d          = tm_q;
    sweep_d       = sweep_q;
    clr_res_d     = clr_res_q;
    order_head_d  = order_head_q;
    order_tail_d  = order_tail_q;
    order_count_d = order_count_q;
    res_status_d  = res_status_q;
    res_value_d   = res_value_q;
    memb_we       = 1'b0;
    memb_waddr    = MEM_AW'(in_elem);
    memb_wdata    = '{valid: 1'b1, team: TEAM_AW'(in_team)};
    ts_we         = 1'b0;
    ts_waddr      = tm_q;
    ts_wdata      = '0;
    slot_we       = 1'b0;
    ring_we       = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        // Sweep membership and team state back to empty
        memb_we    = (int'(sweep_q) < ELEMENT_IDS);
        memb_waddr = MEM_AW'(sweep_q);
        memb_wdata = '0;
        ts_we      = (int'(sweep_q) < TEAMS);
        ts_waddr   = TEAM_AW'(sweep_q);
        ts_wdata   = '0;
        sweep_d    = sweep_q + 1'b1;
        if (sweep_q == SWEEP_LAST) begin
          sweep_d      = '0;
          res_status_d = ST_OK;
          res_value_d  = '0;
          state_d      = clr_res_q ? S_OUT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          func_d       = in_func;
          elem_d       = in_elem;
          res_status_d = ST_OK;
          res_value_d  = '0;
          unique case (in_func)
            F_ASSIGN: begin
              if (int'(in_elem) < ELEMENT_IDS && int'(in_team) < TEAMS) begin
                memb_we = 1'b1;
              end else begin
                res_status_d = ST_UNKNOWN;
              end
              state_d = S_OUT;
            end
            F_ENQUEUE, F_DEQUEUE: begin
              state_d = S_RD1;
            end
            F_CLEAR: begin
              order_head_d  = '0;
              order_tail_d  = '0;
              order_count_d = '0;
              sweep_d       = '0;
              clr_res_d     = 1'b1;
              state_d       = S_CLEAR;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RD1: begin
        // Membership and order ring data are back; pick the team
        if (func_q == F_ENQUEUE) begin
          tm_d = memb_rdata.team;
          if (int'(elem_q) >= ELEMENT_IDS || !memb_rdata.valid) begin
            res_status_d = ST_UNKNOWN;
            state_d      = S_OUT;
          end else begin
            state_d = S_RD2;
          end
        end else begin
          tm_d = ring_rdata;
          if (order_count_q == '0) begin
            res_status_d = ST_EMPTY;
            state_d      = S_OUT;
          end else begin
            state_d = S_RD2;
          end
        end
      end
      S_RD2: begin
        // Team state is back; update it and the order ring
        if (func_q == F_ENQUEUE) begin
          if (int'(ts_rdata.count) >= TEAM_DEPTH) begin
            res_status_d = ST_FULL;
          end else begin
            slot_we        = 1'b1;
            ts_we          = 1'b1;
            ts_wdata.head  = ts_rdata.head;
            ts_wdata.count = ts_rdata.count + 1'b1;
            if (ts_rdata.count == '0) begin
              ring_we       = 1'b1;
              order_tail_d  = otail_next;
              order_count_d = order_count_q + 1'b1;
            end
          end
          state_d = S_OUT;
        end else begin
          if (ts_rdata.count == '0) begin
            res_status_d = ST_EMPTY;
            state_d      = S_OUT;
          end else begin
            ts_we          = 1'b1;
            ts_wdata.head  = head_next;
            ts_wdata.count = ts_rdata.count - 1'b1;
            if (ts_rdata.count == CNT_W'(1)) begin
              order_head_d  = ohead_next;
              order_count_d = order_count_q - 1'b1;
            end
            state_d = S_RD3;
          end
        end
      end
      S_RD3: begin
        // Slot data is back
        res_status_d = ST_VALUE;
        res_value_d  = slot_rdata;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      func_q        <= F_ASSIGN;
      sweep_q       <= '0;
      clr_res_q     <= 1'b0;
      order_head_q  <= '0;
      order_tail_q  <= '0;
      order_count_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      func_q        <= func_d;
      sweep_q       <= sweep_d;
      clr_res_q     <= clr_res_d;
      order_head_q  <= order_head_d;
      order_tail_q  <= order_tail_d;
      order_count_q <= order_count_d;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    elem_q       <= elem_d;
    tm_q         <= tm_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    if (state_q == S_OUT && out_free) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
    end
  end

  // Membership table: valid bit and team per element
  tq_ram #(.Depth(ELEMENT_IDS), .Width($bits(memb_t))) u_memb (
    .clk_i   (clk_i),
    .we_i    (memb_we),
    .waddr_i (memb_waddr),
    .wdata_i (memb_wdata),
    .raddr_i (memb_raddr),
    .rdata_o (memb_rdata)
  );

  // Team head and count
  tq_ram #(.Depth(TEAMS), .Width($bits(team_state_t))) u_team_state (
    .clk_i   (clk_i),
    .we_i    (ts_we),
    .waddr_i (ts_waddr),
    .wdata_i (ts_wdata),
    .raddr_i (ts_raddr),
    .rdata_o (ts_rdata)
  );

  // Element slots of every team FIFO
  tq_ram #(.Depth(SLOTS), .Width(ELEM_W)) u_slots (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (elem_q),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // Team order ring
  tq_ram #(.Depth(TEAMS), .Width(TEAM_AW)) u_order (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (order_tail_q),
    .wdata_i (tm_q),
    .raddr_i (order_head_q),
    .rdata_o (ring_rdata)
  );

  // Checks
  `TQ_ASSERT(a_ocnt_range, order_count_q <= OCNT_W'(TEAMS), "order count beyond team total")
  `TQ_ASSERT(a_ocnt_ptrs, (order_count_q == '0) |-> (order_head_q == order_tail_q), "empty order with split pointers")
  `TQ_ASSERT_NEXT(a_acc_busy, s_axis_tvalid_i && s_axis_tready_o, state_q != S_IDLE, "accepted item not started")
  `TQ_ASSERT_NEXT(a_sweep_end, (state_q == S_CLEAR) && (sweep_q == SWEEP_LAST), state_q != S_CLEAR, "sweep did not finish")
  `TQ_ASSERT_NEXT(a_out_hold, (state_q == S_OUT) && out_valid_q && !m_axis_tready_i, state_q == S_OUT, "result dropped while output busy")

endmodule
